>>> rtl/sm83_pkg.sv
// Shared types and constants for the 8-bit CPU step block.
`default_nettype none
package sm83_pkg;
    localparam int AddrBits = 16;
    localparam logic [AddrBits-1:0] RomLimit = 16'h8000;
    localparam logic [15:0] SpReset = 16'hFFFE;

    localparam logic [7:0] FlagZ = 8'h80;
    localparam logic [7:0] FlagN = 8'h40;
    localparam logic [7:0] FlagH = 8'h20;
    localparam logic [7:0] FlagC = 8'h10;

    localparam logic [1:0] CfgWorkLow  = 2'd0;
    localparam logic [1:0] CfgWorkHigh = 2'd1;
    localparam logic [1:0] CfgHighLow  = 2'd2;
    localparam logic [1:0] CfgHighHigh = 2'd3;

    localparam logic [7:0] OpLdSpMem = 8'h08;
    localparam logic [7:0] OpStop    = 8'h10;
    localparam logic [7:0] OpJr      = 8'h18;
    localparam logic [7:0] OpJrNz    = 8'h20;
    localparam logic [7:0] OpJrZ     = 8'h28;
    localparam logic [7:0] OpJrNc    = 8'h30;
    localparam logic [7:0] OpJrC     = 8'h38;
    localparam logic [7:0] OpAddAB   = 8'h80;

    // one memory port, one access per cycle
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH0,
        ST_FETCH1,
        ST_FETCH2,
        ST_DATA0,
        ST_DATA1,
        ST_EXEC,
        ST_WRITE0,
        ST_WRITE1,
        ST_DONE
    } state_t;

    // memory access request from the sequencer
    typedef struct packed {
        logic        wr_en;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // 8-bit ALU operation codes
    typedef enum logic [2:0] {
        ALU_INC,
        ALU_DEC,
        ALU_ADD,
        ALU_ROT,
        ALU_DAA,
        ALU_CPL,
        ALU_SCF,
        ALU_CCF
    } alu_op_t;
endpackage
`default_nettype wire

>>> rtl/eight_bit_cpu_instruction_step.sv
// Top level: sequencer, register file and memory port of the CPU step block.
//
//  channel | direction | handshake        | beat content
//  s_      | in        | s_valid/s_ready  | func, load_address, load_byte
//  m_      | out       | m_valid/m_ready  | registers after the item, halted
//  cfg     | in        | cfg_wr_en        | window bounds, index 0..3
//
// A load writes its byte, then gives the result beat; a step makes three fetch
// reads, then up to two data accesses, all on the single memory port, then the
// result beat; a step at the ROM limit goes straight to it. Reset clears pc and
// registers, sets sp to FFFE and the windows to defaults; memory is not cleared.
// s_ready is low while an item is at work or its result beat waits.
`default_nettype none
module eight_bit_cpu_instruction_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [15:0] s_load_address,
    input  wire logic [7:0]  s_load_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_prog_counter,
    output logic [15:0]      m_stack_pointer,
    output logic [7:0]       m_acc,
    output logic [7:0]       m_flags,
    output logic [7:0]       m_reg_b,
    output logic [7:0]       m_reg_c,
    output logic [7:0]       m_reg_d,
    output logic [7:0]       m_reg_e,
    output logic [7:0]       m_reg_h,
    output logic [7:0]       m_reg_l,
    output logic             m_halted,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    sm83_pkg::state_t state_reg, state_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]  a_reg, a_next, f_reg, f_next, b_reg, b_next, c_reg, c_next;
    logic [7:0]  d_reg, d_next, e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [7:0]  op_reg, op_next, b1_reg, b1_next, b2_reg, b2_next;
    logic [7:0]  dat_reg, dat_next;
    logic [15:0] wa_reg, wa_next;
    logic [7:0]  w0_reg, w0_next, w1_reg, w1_next;
    logic        w1en_reg, w1en_next;
    logic [15:0] wlo_reg, whi_reg, hlo_reg, hhi_reg;
    logic        valid_reg, valid_next;

    sm83_pkg::mem_req_t req;
    logic [7:0] rdata;
    sm83_pkg::alu_op_t alu_op;
    logic [7:0] alu_a, alu_res, alu_f;

    sm83_mem u_mem (.aclk(aclk), .req(req), .rdata(rdata));
    sm83_alu u_alu (
        .op(alu_op), .rot_sel(op_reg[4:3]), .opa(alu_a), .opb(b_reg),
        .flags_in(f_reg), .result(alu_res), .flags_out(alu_f)
    );

    logic [15:0] bc, de, hl, imm, rr, rr_inc, rr_dec, hl_sum, mem_addr, jr_off;
    logic [16:0] add16;
    logic [12:0] add12;
    logic [1:0]  p;
    logic [2:0]  y;
    logic        q, is_pop, is_push, needs_dat, take;
    logic        in_win;
    logic [7:0]  r8;

    assign bc = {b_reg, c_reg};
    assign de = {d_reg, e_reg};
    assign hl = {h_reg, l_reg};
    assign imm = {b2_reg, b1_reg};
    assign p = op_reg[5:4];
    assign y = op_reg[5:3];
    assign q = op_reg[3];
    assign is_pop = (op_reg & 8'hCF) == 8'hC1;
    assign is_push = (op_reg & 8'hCF) == 8'hC5;

    always_comb begin
        case (p)
            2'd0: rr = bc;
            2'd1: rr = de;
            2'd2: rr = hl;
            default: rr = sp_reg;
        endcase
        case (y)
            3'd0: r8 = b_reg;
            3'd1: r8 = c_reg;
            3'd2: r8 = d_reg;
            3'd3: r8 = e_reg;
            3'd4: r8 = h_reg;
            3'd5: r8 = l_reg;
            3'd6: r8 = dat_reg;
            default: r8 = a_reg;
        endcase
    end
    assign rr_inc = rr + 16'd1;
    assign rr_dec = rr - 16'd1;
    assign add16 = {1'b0, hl} + {1'b0, rr};
    assign add12 = {1'b0, hl[11:0]} + {1'b0, rr[11:0]};
    assign hl_sum = add16[15:0];
    assign mem_addr = (p == 2'd0) ? bc : ((p == 2'd1) ? de : hl);
    assign jr_off = {{8{b1_reg[7]}}, b1_reg};

    // data reads the opcode needs, and the jump condition
    always_comb begin
        needs_dat = 1'b0;
        if (op_reg < 8'h40) begin
            case (op_reg[2:0])
                3'd2: needs_dat = q;
                3'd4, 3'd5: needs_dat = (y == 3'd6);
                default: needs_dat = 1'b0;
            endcase
        end else if (is_pop) begin
            needs_dat = 1'b1;
        end
        case (op_reg)
            sm83_pkg::OpJrNz: take = !f_reg[7];
            sm83_pkg::OpJrZ:  take = f_reg[7];
            sm83_pkg::OpJrNc: take = !f_reg[4];
            sm83_pkg::OpJrC:  take = f_reg[4];
            default:          take = 1'b1;
        endcase
    end

    function automatic logic win(input logic [15:0] a, input logic [15:0] wl,
                                 input logic [15:0] wh, input logic [15:0] hlw,
                                 input logic [15:0] hhw);
        win = (a >= wl && a <= wh) || (a >= hlw && a <= hhw);
    endfunction

    function automatic logic [7:0] hl_dec_hi(input logic [15:0] v);
        logic [15:0] t;
        t = v - 16'd1;
        hl_dec_hi = t[15:8];
    endfunction

    function automatic logic [7:0] hl_dec_lo(input logic [15:0] v);
        logic [15:0] t;
        t = v - 16'd1;
        hl_dec_lo = t[7:0];
    endfunction

    // 8-bit destination select; [HL] goes out as a write
    task automatic put_r8(input logic [7:0] v);
        case (y)
            3'd0: b_next = v;
            3'd1: c_next = v;
            3'd2: d_next = v;
            3'd3: e_next = v;
            3'd4: h_next = v;
            3'd5: l_next = v;
            3'd6: begin
                wa_next = hl;
                w0_next = v;
                state_next = sm83_pkg::ST_WRITE0;
            end
            default: a_next = v;
        endcase
    endtask

    always_comb begin
        in_win = win(mem_addr, wlo_reg, whi_reg, hlo_reg, hhi_reg);
        case (op_reg[2:0])
            3'd4: alu_op = sm83_pkg::ALU_INC;
            3'd5: alu_op = sm83_pkg::ALU_DEC;
            3'd7: begin
                case (y)
                    3'd0, 3'd1, 3'd2, 3'd3: alu_op = sm83_pkg::ALU_ROT;
                    3'd4: alu_op = sm83_pkg::ALU_DAA;
                    3'd5: alu_op = sm83_pkg::ALU_CPL;
                    3'd6: alu_op = sm83_pkg::ALU_SCF;
                    default: alu_op = sm83_pkg::ALU_CCF;
                endcase
            end
            default: alu_op = sm83_pkg::ALU_ADD;
        endcase
        alu_a = (op_reg[2:0] == 3'd4 || op_reg[2:0] == 3'd5) ? r8 : a_reg;
    end

    always_comb begin
        state_next = state_reg;
        pc_next = pc_reg; sp_next = sp_reg;
        a_next = a_reg; f_next = f_reg; b_next = b_reg; c_next = c_reg;
        d_next = d_reg; e_next = e_reg; h_next = h_reg; l_next = l_reg;
        op_next = op_reg; b1_next = b1_reg; b2_next = b2_reg; dat_next = dat_reg;
        wa_next = wa_reg; w0_next = w0_reg; w1_next = w1_reg; w1en_next = w1en_reg;
        valid_next = valid_reg;
        req.wr_en = 1'b0;
        req.addr = pc_reg;
        req.wdata = w0_reg;
        s_ready = 1'b0;
        case (state_reg)
            sm83_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (!s_func) begin
                        req.wr_en = 1'b1;
                        req.addr = s_load_address;
                        req.wdata = s_load_byte;
                        state_next = sm83_pkg::ST_DONE;
                    end else if (pc_reg >= sm83_pkg::RomLimit) begin
                        state_next = sm83_pkg::ST_DONE;
                    end else begin
                        req.addr = pc_reg;
                        state_next = sm83_pkg::ST_FETCH0;
                    end
                end
            end
            sm83_pkg::ST_FETCH0: begin
                op_next = rdata;
                req.addr = pc_reg + 16'd1;
                state_next = sm83_pkg::ST_FETCH1;
            end
            sm83_pkg::ST_FETCH1: begin
                b1_next = rdata;
                req.addr = pc_reg + 16'd2;
                state_next = sm83_pkg::ST_FETCH2;
            end
            sm83_pkg::ST_FETCH2: begin
                b2_next = rdata;
                if (is_pop) req.addr = sp_reg;
                else if (op_reg[2:0] == 3'd2) req.addr = mem_addr;
                else req.addr = hl;
                state_next = needs_dat ? sm83_pkg::ST_DATA0 : sm83_pkg::ST_EXEC;
            end
            sm83_pkg::ST_DATA0: begin
                dat_next = rdata;
                req.addr = sp_reg + 16'd1;
                state_next = is_pop ? sm83_pkg::ST_DATA1 : sm83_pkg::ST_EXEC;
            end
            sm83_pkg::ST_DATA1: begin
                // dat holds low byte, rdata the high byte
                if (p == 2'd0) begin b_next = rdata; c_next = dat_reg; end
                else if (p == 2'd1) begin d_next = rdata; e_next = dat_reg; end
                else if (p == 2'd2) begin h_next = rdata; l_next = dat_reg; end
                else begin a_next = rdata; f_next = {dat_reg[7:4], 4'h0}; end
                sp_next = sp_reg + 16'd2;
                pc_next = pc_reg + 16'd1;
                state_next = sm83_pkg::ST_DONE;
            end
            sm83_pkg::ST_EXEC: begin
                pc_next = pc_reg + 16'd1;
                state_next = sm83_pkg::ST_DONE;
                w1en_next = 1'b0;
                if (op_reg < 8'h40) begin
                    case (op_reg[2:0])
                        3'd0: begin
                            if (op_reg == sm83_pkg::OpLdSpMem) begin
                                pc_next = pc_reg + 16'd3;
                                if (win(imm, wlo_reg, whi_reg, hlo_reg, hhi_reg)) begin
                                    wa_next = imm;
                                    w0_next = sp_reg[7:0];
                                    w1_next = sp_reg[15:8];
                                    w1en_next = 1'b1;
                                    state_next = sm83_pkg::ST_WRITE0;
                                end
                            end else if (op_reg == sm83_pkg::OpStop) begin
                                pc_next = pc_reg + 16'd2;
                            end else if (op_reg >= sm83_pkg::OpJr) begin
                                pc_next = pc_reg + 16'd2 + (take ? jr_off : 16'd0);
                            end
                        end
                        3'd1: begin
                            if (!q) begin
                                pc_next = pc_reg + 16'd3;
                                case (p)
                                    2'd0: begin b_next = b2_reg; c_next = b1_reg; end
                                    2'd1: begin d_next = b2_reg; e_next = b1_reg; end
                                    2'd2: begin h_next = b2_reg; l_next = b1_reg; end
                                    default: sp_next = imm;
                                endcase
                            end else begin
                                h_next = hl_sum[15:8];
                                l_next = hl_sum[7:0];
                                f_next = {f_reg[7], 1'b0, add12[12], add16[16], 4'h0};
                            end
                        end
                        3'd2: begin
                            if (!q) begin
                                if (in_win) begin
                                    wa_next = mem_addr;
                                    w0_next = a_reg;
                                    state_next = sm83_pkg::ST_WRITE0;
                                end
                            end else begin
                                a_next = dat_reg;
                            end
                            if (p == 2'd2) begin
                                h_next = rr_inc[15:8]; l_next = rr_inc[7:0];
                            end else if (p == 2'd3) begin
                                h_next = hl_dec_hi(hl); l_next = hl_dec_lo(hl);
                            end
                        end
                        3'd3: begin
                            case (p)
                                2'd0: begin
                                    {b_next, c_next} = q ? rr_dec : rr_inc;
                                end
                                2'd1: begin
                                    {d_next, e_next} = q ? rr_dec : rr_inc;
                                end
                                2'd2: begin
                                    {h_next, l_next} = q ? rr_dec : rr_inc;
                                end
                                default: sp_next = q ? rr_dec : rr_inc;
                            endcase
                        end
                        3'd4, 3'd5: begin
                            f_next = {alu_f[7:5], f_reg[4], 4'h0};
                            put_r8(alu_res);
                        end
                        3'd6: begin
                            pc_next = pc_reg + 16'd2;
                            put_r8(b1_reg);
                        end
                        default: begin
                            a_next = alu_res;
                            f_next = alu_f;
                        end
                    endcase
                end else if (op_reg == sm83_pkg::OpAddAB) begin
                    a_next = alu_res;
                    f_next = alu_f;
                end else if (is_push) begin
                    sp_next = sp_reg - 16'd2;
                    wa_next = sp_reg - 16'd2;
                    w1en_next = 1'b1;
                    state_next = sm83_pkg::ST_WRITE0;
                    case (p)
                        2'd0: begin w0_next = c_reg; w1_next = b_reg; end
                        2'd1: begin w0_next = e_reg; w1_next = d_reg; end
                        2'd2: begin w0_next = l_reg; w1_next = h_reg; end
                        default: begin w0_next = f_reg; w1_next = a_reg; end
                    endcase
                end
            end
            sm83_pkg::ST_WRITE0: begin
                req.wr_en = 1'b1;
                req.addr = wa_reg;
                req.wdata = w0_reg;
                state_next = w1en_reg ? sm83_pkg::ST_WRITE1 : sm83_pkg::ST_DONE;
            end
            sm83_pkg::ST_WRITE1: begin
                req.wr_en = 1'b1;
                req.addr = wa_reg + 16'd1;
                req.wdata = w1_reg;
                state_next = sm83_pkg::ST_DONE;
            end
            sm83_pkg::ST_DONE: begin
                valid_next = 1'b1;
                if (valid_reg && m_ready) begin
                    valid_next = 1'b0;
                    state_next = sm83_pkg::ST_IDLE;
                end
            end
            default: state_next = sm83_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sm83_pkg::ST_IDLE;
            pc_reg <= 16'd0;
            sp_reg <= sm83_pkg::SpReset;
            a_reg <= 8'd0; f_reg <= 8'd0; b_reg <= 8'd0; c_reg <= 8'd0;
            d_reg <= 8'd0; e_reg <= 8'd0; h_reg <= 8'd0; l_reg <= 8'd0;
            valid_reg <= 1'b0;
            w1en_reg <= 1'b0;
            wlo_reg <= 16'hC000; whi_reg <= 16'hDFFF;
            hlo_reg <= 16'hFF80; hhi_reg <= 16'hFFFE;
        end else begin
            state_reg <= state_next;
            pc_reg <= pc_next; sp_reg <= sp_next;
            a_reg <= a_next; f_reg <= f_next; b_reg <= b_next; c_reg <= c_next;
            d_reg <= d_next; e_reg <= e_next; h_reg <= h_next; l_reg <= l_next;
            valid_reg <= valid_next;
            w1en_reg <= w1en_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    sm83_pkg::CfgWorkLow:  wlo_reg <= cfg_data;
                    sm83_pkg::CfgWorkHigh: whi_reg <= cfg_data;
                    sm83_pkg::CfgHighLow:  hlo_reg <= cfg_data;
                    sm83_pkg::CfgHighHigh: hhi_reg <= cfg_data;
                    default: wlo_reg <= wlo_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next; b1_reg <= b1_next; b2_reg <= b2_next;
        dat_reg <= dat_next;
        wa_reg <= wa_next; w0_reg <= w0_next; w1_reg <= w1_next;
    end

    assign m_valid = valid_reg;
    assign m_prog_counter = pc_reg;
    assign m_stack_pointer = sp_reg;
    assign m_acc = a_reg;
    assign m_flags = {f_reg[7:4], 4'h0};
    assign m_reg_b = b_reg;
    assign m_reg_c = c_reg;
    assign m_reg_d = d_reg;
    assign m_reg_e = e_reg;
    assign m_reg_h = h_reg;
    assign m_reg_l = l_reg;
    assign m_halted = (pc_reg >= sm83_pkg::RomLimit);
endmodule
`default_nettype wire

>>> rtl/sm83_mem.sv
// 64K x 8 single-port main memory with registered read.
`default_nettype none
module sm83_mem (
    input  wire logic              aclk,
    input  wire sm83_pkg::mem_req_t req,
    output logic [7:0]             rdata
);
    logic [7:0] mem_array [0:(1<<sm83_pkg::AddrBits)-1];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_array[req.addr] <= req.wdata;
        end
        rdata_reg <= mem_array[req.addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> rtl/sm83_alu.sv
// Shared 8-bit ALU: inc/dec, add, rotates, DAA and flag operations.
`default_nettype none
module sm83_alu (
    input  wire sm83_pkg::alu_op_t op,
    input  wire logic [1:0]        rot_sel,
    input  wire logic [7:0]        opa,
    input  wire logic [7:0]        opb,
    input  wire logic [7:0]        flags_in,
    output logic [7:0]             result,
    output logic [7:0]             flags_out
);
    logic [8:0] sum;
    logic [7:0] adj;
    logic       cy;
    logic       zf, nf, hf, cf;

    always_comb begin
        zf = flags_in[7];
        nf = flags_in[6];
        hf = flags_in[5];
        cf = flags_in[4];
        sum = 9'd0;
        adj = 8'd0;
        cy = cf;
        result = opa;
        case (op)
            sm83_pkg::ALU_INC: begin
                result = opa + 8'd1;
                zf = (result == 8'd0);
                nf = 1'b0;
                hf = (opa[3:0] == 4'hF);
            end
            sm83_pkg::ALU_DEC: begin
                result = opa - 8'd1;
                zf = (result == 8'd0);
                nf = 1'b1;
                hf = (opa[3:0] == 4'h0);
            end
            sm83_pkg::ALU_ADD: begin
                sum = {1'b0, opa} + {1'b0, opb};
                result = sum[7:0];
                zf = (result == 8'd0);
                nf = 1'b0;
                hf = ({1'b0, opa[3:0]} + {1'b0, opb[3:0]}) > 5'h0F;
                cf = sum[8];
            end
            sm83_pkg::ALU_ROT: begin
                case (rot_sel)
                    2'd0: begin cy = opa[7]; result = {opa[6:0], opa[7]}; end
                    2'd1: begin cy = opa[0]; result = {opa[0], opa[7:1]}; end
                    2'd2: begin cy = opa[7]; result = {opa[6:0], flags_in[4]}; end
                    default: begin cy = opa[0]; result = {flags_in[4], opa[7:1]}; end
                endcase
                zf = 1'b0;
                nf = 1'b0;
                hf = 1'b0;
                cf = cy;
            end
            sm83_pkg::ALU_DAA: begin
                if (!nf) begin
                    if (cf || opa > 8'h99) begin
                        adj = adj | 8'h60;
                        cy = 1'b1;
                    end
                    if (hf || opa[3:0] > 4'h9) begin
                        adj = adj | 8'h06;
                    end
                    result = opa + adj;
                end else begin
                    result = opa - (cf ? 8'h60 : 8'h00) - (hf ? 8'h06 : 8'h00);
                end
                zf = (result == 8'd0);
                hf = 1'b0;
                cf = cy;
            end
            sm83_pkg::ALU_CPL: begin
                result = ~opa;
                nf = 1'b1;
                hf = 1'b1;
            end
            sm83_pkg::ALU_SCF: begin
                nf = 1'b0;
                hf = 1'b0;
                cf = 1'b1;
            end
            sm83_pkg::ALU_CCF: begin
                nf = 1'b0;
                hf = 1'b0;
                cf = ~flags_in[4];
            end
            default: begin
                result = opa;
            end
        endcase
        flags_out = {zf, nf, hf, cf, 4'h0};
    end
endmodule
`default_nettype wire

>>> sim/eight_bit_cpu_instruction_step_tb.sv
// Self-checking testbench for the 8-bit CPU instruction step block.
`timescale 1ns / 100ps
module eight_bit_cpu_instruction_step_tb;

    localparam int CycleLimit = 1500000;
    localparam int DrainCycles = 16;
    localparam int RandomItems = 1600;

    localparam logic [7:0] OpLdABc    = 8'h0A;
    localparam logic [7:0] OpLdADe    = 8'h1A;
    localparam logic [7:0] OpLdAHlInc = 8'h2A;
    localparam logic [7:0] OpLdAHlDec = 8'h3A;
    localparam logic [7:0] OpIncHlMem = 8'h34;
    localparam logic [7:0] OpDecHlMem = 8'h35;
    localparam logic [7:0] OpLdSpImm  = 8'h31;
    localparam logic [7:0] OpRlca     = 8'h07;
    localparam logic [7:0] OpRra      = 8'h1F;
    localparam logic [7:0] OpDaa      = 8'h27;
    localparam logic [7:0] OpCpl      = 8'h2F;
    localparam logic [7:0] OpScf      = 8'h37;
    localparam logic [7:0] OpCcf      = 8'h3F;
    localparam logic [7:0] OpLdBB     = 8'h40;
    localparam logic [7:0] OpPopBc    = 8'hC1;
    localparam logic [7:0] OpPushBc   = 8'hC5;
    localparam logic [7:0] OpPopAf    = 8'hF1;

    typedef struct {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a, f, b, c, d, e, h, l;
        logic        halt;
    } cpu_view_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [15:0] s_load_address = '0;
    logic [7:0]  s_load_byte = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_prog_counter, m_stack_pointer;
    logic [7:0]  m_acc, m_flags, m_reg_b, m_reg_c, m_reg_d, m_reg_e, m_reg_h, m_reg_l;
    logic        m_halted;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    eight_bit_cpu_instruction_step dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor state
    logic [7:0]  mem [0:65535];
    bit          seen [0:65535];
    logic [15:0] cpu_pc, cpu_sp;
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [15:0] win_wl, win_wh, win_hl, win_hh;

    cpu_view_t   pending_regs[$];
    int          errors = 0;
    int          items_sent = 0;
    int          steps_run = 0;
    int          halted_seen = 0;
    int          cycles = 0;
    bit          calm = 1'b0;

    function automatic bit writable(input logic [15:0] a);
        return (a >= win_wl && a <= win_wh) || (a >= win_hl && a <= win_hh);
    endfunction

    function automatic void mem_put(input logic [15:0] a, input logic [7:0] v);
        mem[a] = v;
        seen[a] = 1'b1;
    endfunction

    function automatic void set_flag(input logic [7:0] mask, input bit on);
        r_f = ((r_f & ~mask) | (on ? mask : 8'h00)) & 8'hF0;
    endfunction

    function automatic logic [15:0] get_pair(input logic [1:0] p);
        case (p)
            2'd0: return {r_b, r_c};
            2'd1: return {r_d, r_e};
            2'd2: return {r_h, r_l};
            default: return cpu_sp;
        endcase
    endfunction

    function automatic void put_pair(input logic [1:0] p, input logic [15:0] v);
        case (p)
            2'd0: {r_b, r_c} = v;
            2'd1: {r_d, r_e} = v;
            2'd2: {r_h, r_l} = v;
            default: cpu_sp = v;
        endcase
    endfunction

    function automatic logic [7:0] get_r8(input logic [2:0] y);
        case (y)
            3'd0: return r_b;
            3'd1: return r_c;
            3'd2: return r_d;
            3'd3: return r_e;
            3'd4: return r_h;
            3'd5: return r_l;
            3'd6: return mem[{r_h, r_l}];
            default: return r_a;
        endcase
    endfunction

    function automatic void put_r8(input logic [2:0] y, input logic [7:0] v);
        case (y)
            3'd0: r_b = v;
            3'd1: r_c = v;
            3'd2: r_d = v;
            3'd3: r_e = v;
            3'd4: r_h = v;
            3'd5: r_l = v;
            3'd6: mem_put({r_h, r_l}, v);
            default: r_a = v;
        endcase
    endfunction

    function automatic void run_instruction();
        logic [7:0]  op, b1, v, s, adj, lo, hi;
        logic [15:0] imm, npc, addr, hl, w;
        logic [16:0] sum17;
        logic [8:0]  sum9;
        logic [2:0]  y;
        logic [1:0]  p;
        bit          q, take, cy, out;
        op = mem[cpu_pc];
        b1 = mem[cpu_pc + 16'd1];
        imm = {mem[cpu_pc + 16'd2], b1};
        npc = cpu_pc + 16'd1;
        y = op[5:3];
        p = op[5:4];
        q = op[3];
        if (op < 8'h40) begin
            case (op[2:0])
                3'd0: begin
                    if (op == sm83_pkg::OpLdSpMem) begin
                        if (writable(imm)) begin
                            mem_put(imm, cpu_sp[7:0]);
                            mem_put(imm + 16'd1, cpu_sp[15:8]);
                        end
                        npc = cpu_pc + 16'd3;
                    end else if (op == sm83_pkg::OpStop) begin
                        npc = cpu_pc + 16'd2;
                    end else if (op >= sm83_pkg::OpJr) begin
                        take = 1'b1;
                        if (op == sm83_pkg::OpJrNz) take = !r_f[7];
                        if (op == sm83_pkg::OpJrZ)  take = r_f[7];
                        if (op == sm83_pkg::OpJrNc) take = !r_f[4];
                        if (op == sm83_pkg::OpJrC)  take = r_f[4];
                        npc = cpu_pc + 16'd2;
                        if (take) npc = npc + {{8{b1[7]}}, b1};
                    end
                end
                3'd1: begin
                    if (!q) begin
                        put_pair(p, imm);
                        npc = cpu_pc + 16'd3;
                    end else begin
                        hl = {r_h, r_l};
                        w = get_pair(p);
                        sum17 = {1'b0, hl} + {1'b0, w};
                        {r_h, r_l} = sum17[15:0];
                        set_flag(sm83_pkg::FlagN, 1'b0);
                        set_flag(sm83_pkg::FlagH,
                                 ({1'b0, hl[11:0]} + {1'b0, w[11:0]}) > 13'hFFF);
                        set_flag(sm83_pkg::FlagC, sum17[16]);
                    end
                end
                3'd2: begin
                    addr = (p < 2) ? get_pair(p) : {r_h, r_l};
                    if (!q) begin
                        if (writable(addr)) mem_put(addr, r_a);
                    end else begin
                        r_a = mem[addr];
                    end
                    if (p == 2) {r_h, r_l} = addr + 16'd1;
                    if (p == 3) {r_h, r_l} = addr - 16'd1;
                end
                3'd3: put_pair(p, q ? get_pair(p) - 16'd1 : get_pair(p) + 16'd1);
                3'd4: begin
                    v = get_r8(y);
                    s = v + 8'd1;
                    put_r8(y, s);
                    set_flag(sm83_pkg::FlagZ, s == 8'h00);
                    set_flag(sm83_pkg::FlagN, 1'b0);
                    set_flag(sm83_pkg::FlagH, v[3:0] == 4'hF);
                end
                3'd5: begin
                    v = get_r8(y);
                    s = v - 8'd1;
                    put_r8(y, s);
                    set_flag(sm83_pkg::FlagZ, s == 8'h00);
                    set_flag(sm83_pkg::FlagN, 1'b1);
                    set_flag(sm83_pkg::FlagH, v[3:0] == 4'h0);
                end
                3'd6: begin
                    put_r8(y, b1);
                    npc = cpu_pc + 16'd2;
                end
                default: begin
                    if (y < 4) begin
                        cy = r_f[4];
                        case (y[1:0])
                            2'd0: begin out = r_a[7]; r_a = {r_a[6:0], out}; end
                            2'd1: begin out = r_a[0]; r_a = {out, r_a[7:1]}; end
                            2'd2: begin out = r_a[7]; r_a = {r_a[6:0], cy}; end
                            default: begin out = r_a[0]; r_a = {cy, r_a[7:1]}; end
                        endcase
                        r_f = out ? sm83_pkg::FlagC : 8'h00;
                    end else if (y == 4) begin
                        cy = r_f[4];
                        if (!r_f[6]) begin
                            adj = 8'h00;
                            if (cy || r_a > 8'h99) begin
                                adj = adj | 8'h60;
                                cy = 1'b1;
                            end
                            if (r_f[5] || r_a[3:0] > 4'h9) adj = adj | 8'h06;
                            r_a = r_a + adj;
                        end else begin
                            if (cy) r_a = r_a - 8'h60;
                            if (r_f[5]) r_a = r_a - 8'h06;
                        end
                        set_flag(sm83_pkg::FlagZ, r_a == 8'h00);
                        set_flag(sm83_pkg::FlagH, 1'b0);
                        set_flag(sm83_pkg::FlagC, cy);
                    end else if (y == 5) begin
                        r_a = ~r_a;
                        set_flag(sm83_pkg::FlagN, 1'b1);
                        set_flag(sm83_pkg::FlagH, 1'b1);
                    end else begin
                        cy = (y == 6) ? 1'b1 : !r_f[4];
                        set_flag(sm83_pkg::FlagN, 1'b0);
                        set_flag(sm83_pkg::FlagH, 1'b0);
                        set_flag(sm83_pkg::FlagC, cy);
                    end
                end
            endcase
        end else if (op == sm83_pkg::OpAddAB) begin
            sum9 = {1'b0, r_a} + {1'b0, r_b};
            set_flag(sm83_pkg::FlagH, ({1'b0, r_a[3:0]} + {1'b0, r_b[3:0]}) > 5'h0F);
            r_a = sum9[7:0];
            set_flag(sm83_pkg::FlagZ, sum9[7:0] == 8'h00);
            set_flag(sm83_pkg::FlagN, 1'b0);
            set_flag(sm83_pkg::FlagC, sum9[8]);
        end else if ((op & 8'hCF) == OpPopBc) begin
            lo = mem[cpu_sp];
            cpu_sp = cpu_sp + 16'd1;
            hi = mem[cpu_sp];
            cpu_sp = cpu_sp + 16'd1;
            if (p == 3) {r_a, r_f} = {hi, lo & 8'hF0};
            else put_pair(p, {hi, lo});
        end else if ((op & 8'hCF) == OpPushBc) begin
            w = (p == 3) ? {r_a, r_f} : get_pair(p);
            cpu_sp = cpu_sp - 16'd1;
            mem_put(cpu_sp, w[15:8]);
            cpu_sp = cpu_sp - 16'd1;
            mem_put(cpu_sp, w[7:0]);
        end
        cpu_pc = npc;
    endfunction

    function automatic void predict_beat(input bit fn, input logic [15:0] la,
                                         input logic [7:0] lb);
        cpu_view_t v;
        if (!fn) begin
            mem_put(la, lb);
        end else if (cpu_pc < sm83_pkg::RomLimit) begin
            run_instruction();
            steps_run++;
        end
        v.pc = cpu_pc;
        v.sp = cpu_sp;
        v.a = r_a;
        v.f = r_f;
        v.b = r_b;
        v.c = r_c;
        v.d = r_d;
        v.e = r_e;
        v.h = r_h;
        v.l = r_l;
        v.halt = cpu_pc >= sm83_pkg::RomLimit;
        if (v.halt && fn) halted_seen++;
        pending_regs.push_back(v);
    endfunction

    // input side: leaves s_valid high after the accepting edge
    task automatic send_beat(input bit fn, input logic [15:0] la, input logic [7:0] lb);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_load_address <= la;
        s_load_byte <= lb;
        do @(posedge aclk); while (!s_ready);
        predict_beat(fn, la, lb);
        items_sent++;
    endtask

    task automatic load_if_blank(input logic [15:0] a, input logic [7:0] v);
        if (!seen[a]) send_beat(1'b0, a, v);
    endtask

    function automatic logic [7:0] pick_opcode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 68) return 8'($urandom_range(0, 63));
        if (r < 73) return OpLdBB;
        if (r < 81) return sm83_pkg::OpAddAB;
        if (r < 87) return OpPopBc | {2'b00, 2'($urandom_range(0, 3)), 4'h0};
        if (r < 95) return OpPushBc | {2'b00, 2'($urandom_range(0, 3)), 4'h0};
        return 8'($urandom_range(0, 255));
    endfunction

    // one step at pc, with every byte it reads written first
    task automatic step_cpu();
        logic [7:0] op;
        int target;
        load_if_blank(cpu_pc, pick_opcode());
        load_if_blank(cpu_pc + 16'd1, 8'($urandom_range(0, 255)));
        load_if_blank(cpu_pc + 16'd2, 8'($urandom_range(0, 255)));
        op = mem[cpu_pc];
        if (op == sm83_pkg::OpJr || op == sm83_pkg::OpJrNz || op == sm83_pkg::OpJrZ ||
            op == sm83_pkg::OpJrNc || op == sm83_pkg::OpJrC) begin
            target = int'(cpu_pc) + 2 + int'($signed(mem[cpu_pc + 16'd1]));
            // keep the random walk in low memory
            if (target < 0 || target > 32'h7000)
                send_beat(1'b0, cpu_pc + 16'd1, 8'($urandom_range(0, 127)));
        end
        if (op == OpLdABc) load_if_blank({r_b, r_c}, 8'($urandom_range(0, 255)));
        if (op == OpLdADe) load_if_blank({r_d, r_e}, 8'($urandom_range(0, 255)));
        if (op == OpLdAHlInc || op == OpLdAHlDec || op == OpIncHlMem || op == OpDecHlMem)
            load_if_blank({r_h, r_l}, 8'($urandom_range(0, 255)));
        if ((op & 8'hCF) == OpPopBc) begin
            load_if_blank(cpu_sp, 8'($urandom_range(0, 255)));
            load_if_blank(cpu_sp + 16'd1, 8'($urandom_range(0, 255)));
        end
        send_beat(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_regs.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);
    endtask

    task automatic write_window(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            sm83_pkg::CfgWorkLow:  win_wl = val;
            sm83_pkg::CfgWorkHigh: win_wh = val;
            sm83_pkg::CfgHighLow:  win_hl = val;
            default:               win_hh = val;
        endcase
    endtask

    task automatic set_windows(input logic [15:0] wl, input logic [15:0] wh,
                               input logic [15:0] hl, input logic [15:0] hh);
        write_window(sm83_pkg::CfgWorkLow, wl);
        write_window(sm83_pkg::CfgWorkHigh, wh);
        write_window(sm83_pkg::CfgHighLow, hl);
        write_window(sm83_pkg::CfgHighHigh, hh);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed_ops();
        logic [7:0] prog [$];
        prog = '{OpLdSpImm, 8'h01, 8'h00, OpPushBc, OpPopAf, OpScf, OpDaa, OpCcf,
                 OpCpl, sm83_pkg::OpAddAB, OpRlca, OpRra, sm83_pkg::OpStop, 8'h00,
                 sm83_pkg::OpLdSpMem, 8'hFE, 8'hFF};
        send_beat(1'b0, 16'hFFFF, 8'hFF);
        foreach (prog[i]) send_beat(1'b0, 16'(i), prog[i]);
        repeat (12) step_cpu();
    endtask

    task automatic test_random_programs();
        int phase_end;
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: set_windows(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000);
                1: set_windows(16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
                2: set_windows(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                default: set_windows(16'hC000, 16'hDFFF, 16'hFF80, 16'hFFFE);
            endcase
            phase_end = items_sent + RandomItems / 4;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 85) step_cpu();
                else send_beat(1'b0, 16'($urandom_range(0, 65535)),
                               8'($urandom_range(0, 255)));
            end
        end
    endtask

    // move pc out of the ROM area with a chain of jumps: backward hops wrap
    // below zero to the top of memory, forward hops cross the limit
    task automatic test_halt();
        logic [7:0] hop;
        calm = 1'b1;
        hop = (cpu_pc < 16'h4000) ? 8'h80 : 8'h7F;
        while (cpu_pc < sm83_pkg::RomLimit) begin
            send_beat(1'b0, cpu_pc, sm83_pkg::OpJr);
            send_beat(1'b0, cpu_pc + 16'd1, hop);
            send_beat(1'b0, cpu_pc + 16'd2, 8'($urandom_range(0, 255)));
            send_beat(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
        repeat (4) send_beat(1'b1, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        send_beat(1'b0, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    endtask

    // result side: random stall bursts, none once calm
    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        cpu_view_t w;
        if (aresetn && m_valid && m_ready) begin
            if (pending_regs.size() == 0) begin
                $error("result beat with nothing pending");
                errors++;
            end else begin
                w = pending_regs.pop_front();
                check_field("prog_counter", int'(w.pc), int'(m_prog_counter));
                check_field("stack_pointer", int'(w.sp), int'(m_stack_pointer));
                check_field("acc", int'(w.a), int'(m_acc));
                check_field("flags", int'(w.f), int'(m_flags));
                check_field("reg_b", int'(w.b), int'(m_reg_b));
                check_field("reg_c", int'(w.c), int'(m_reg_c));
                check_field("reg_d", int'(w.d), int'(m_reg_d));
                check_field("reg_e", int'(w.e), int'(m_reg_e));
                check_field("reg_h", int'(w.h), int'(m_reg_h));
                check_field("reg_l", int'(w.l), int'(m_reg_l));
                check_field("halted", int'(w.halt), int'(m_halted));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cpu_pc = '0;
        cpu_sp = sm83_pkg::SpReset;
        {r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l} = '0;
        win_wl = 16'hC000;
        win_wh = 16'hDFFF;
        win_hl = 16'hFF80;
        win_hh = 16'hFFFE;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_ops();
        test_random_programs();
        test_halt();
        drain();
        $display("Ran %0d input beats: %0d executed instructions, %0d halted steps,",
                 items_sent, steps_run, halted_seen);
        $display("four store-window settings including full, empty and inverted ranges.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
